// ===== hw/rtl/scf_pkg.sv =====
// types, constants and helper functions shared by the stick command framer
// no dependencies; used by scf_front, scf_queue, scf_back and the top level
package scf_pkg;

    localparam int PULSE_W   = 11;
    localparam int AXIS_W    = 16;
    localparam int HEIGHT_W  = 32;
    localparam int FLAGS_W   = 3;
    localparam int BTN_W     = 12;
    localparam int HAT_W     = 4;
    localparam int CMD_W     = 3;
    localparam int FRAME_LEN = 17;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 3'd0,
        CMD_SEND    = 3'd1,
        CMD_TELEM   = 3'd2,
        CMD_TAKEOFF = 3'd3,
        CMD_LAND    = 3'd4
    } t_cmd;

    // axis gains
    localparam logic signed [PULSE_W-1:0] GAIN_ROLL     = 11'sd250;
    localparam logic signed [PULSE_W-1:0] GAIN_PITCH    = -11'sd250;
    localparam logic signed [PULSE_W-1:0] GAIN_YAW      = 11'sd250;
    localparam logic signed [PULSE_W-1:0] GAIN_THROTTLE = -11'sd500;

    localparam logic [PULSE_W-1:0] PULSE_CENTER    = 11'd1500;
    localparam logic [PULSE_W-1:0] THR_FORCE_LIMIT = 11'd1100;
    localparam logic [PULSE_W-1:0] YAW_PULSE_MIN   = 11'd1000;
    localparam logic [PULSE_W-1:0] YAW_PULSE_MAX   = 11'd2000;

    localparam logic [HEIGHT_W-1:0] LAND_HEIGHT = 32'hFFFF_FFD8; // -40

    // hat codes
    localparam logic [HAT_W-1:0] HAT_UP   = 4'd1;
    localparam logic [HAT_W-1:0] HAT_DOWN = 4'd4;

    // button numbers
    localparam int BTN_YAW_DOWN  = 2;
    localparam int BTN_YAW_UP    = 3;
    localparam int BTN_SERVO_OFF = 8;
    localparam int BTN_SERVO_ON  = 9;
    localparam int BTN_ALT_OFF   = 10;
    localparam int BTN_ALT_ON    = 11;

    // flag bits
    localparam int FLAG_SEND  = 0;
    localparam int FLAG_ALT   = 1;
    localparam int FLAG_SERVO = 2;

    // frame header and checksum span
    localparam logic [7:0] HDR0 = 8'h40;
    localparam logic [7:0] HDR1 = 8'h26;
    localparam logic [7:0] HDR2 = 8'h2A;
    localparam logic [IDX_W-1:0] CSUM_FIRST = IDX_W'(3);
    localparam logic [IDX_W-1:0] CSUM_LAST  = IDX_W'(15);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_LEN - 1);

    typedef struct packed {
        logic [PULSE_W-1:0]  roll;
        logic [PULSE_W-1:0]  pitch;
        logic [PULSE_W-1:0]  yaw;
        logic [PULSE_W-1:0]  throttle;
        logic [HEIGHT_W-1:0] height;
        logic [FLAGS_W-1:0]  flags;
    } t_frame;

    // (gain * raw) / 32768 truncated toward zero, plus center
    function automatic logic [PULSE_W-1:0] axis_pulse(
        input logic signed [PULSE_W-1:0] gain,
        input logic signed [AXIS_W-1:0]  raw
    );
        logic signed [26:0] prod;
        logic signed [26:0] biased;
        logic signed [11:0] quot;
        logic signed [11:0] sum;
        prod   = 27'(gain) * 27'(raw);
        biased = prod + (prod[26] ? 27'sd32767 : 27'sd0);
        quot   = 12'(biased >>> 15);
        sum    = quot + 12'sd1500;
        return sum[PULSE_W-1:0];
    endfunction

    // byte of the frame at a given position; checksum passed in
    function automatic logic [7:0] frame_byte(
        input t_frame           f,
        input logic [IDX_W-1:0] idx,
        input logic [7:0]       csum
    );
        logic [7:0] b;
        case (idx)
            5'd0:    b = HDR0;
            5'd1:    b = HDR1;
            5'd2:    b = HDR2;
            5'd3:    b = {5'b0, f.roll[10:8]};
            5'd4:    b = f.roll[7:0];
            5'd5:    b = {5'b0, f.pitch[10:8]};
            5'd6:    b = f.pitch[7:0];
            5'd7:    b = {5'b0, f.yaw[10:8]};
            5'd8:    b = f.yaw[7:0];
            5'd9:    b = {5'b0, f.throttle[10:8]};
            5'd10:   b = f.throttle[7:0];
            5'd11:   b = f.height[7:0];
            5'd12:   b = f.height[15:8];
            5'd13:   b = f.height[23:16];
            5'd14:   b = f.height[31:24];
            5'd15:   b = {5'b0, f.flags};
            default: b = csum;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/scf_front.sv =====
// front end: decodes commands, keeps pulses, height, offset, altitude and flags
// depends on scf_pkg; pushes frame snapshots into scf_queue
module scf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [scf_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [scf_pkg::AXIS_W-1:0] i_axis_roll,
    input  logic signed [scf_pkg::AXIS_W-1:0] i_axis_pitch,
    input  logic signed [scf_pkg::AXIS_W-1:0] i_axis_yaw,
    input  logic signed [scf_pkg::AXIS_W-1:0] i_axis_throttle,
    input  logic [scf_pkg::BTN_W-1:0]         i_buttons,
    input  logic [scf_pkg::HAT_W-1:0]         i_hat,
    input  logic [scf_pkg::HEIGHT_W-1:0]      i_telemetry_altitude,
    input  logic [scf_pkg::HEIGHT_W-1:0]      i_takeoff_height,
    output logic                              o_push,
    output scf_pkg::t_frame                   o_push_frame
);

    logic [scf_pkg::PULSE_W-1:0]  r_roll, n_roll;
    logic [scf_pkg::PULSE_W-1:0]  r_pitch, n_pitch;
    logic [scf_pkg::PULSE_W-1:0]  r_yaw, n_yaw;
    logic [scf_pkg::PULSE_W-1:0]  r_throttle, n_throttle;
    logic [scf_pkg::HEIGHT_W-1:0] r_height, n_height;
    logic [scf_pkg::HEIGHT_W-1:0] r_offset, n_offset;
    logic [scf_pkg::HEIGHT_W-1:0] r_alt, n_alt;
    logic [scf_pkg::FLAGS_W-1:0]  r_flags, n_flags;

    logic [scf_pkg::PULSE_W-1:0] throttle_p;
    logic                        yaw_force;

    assign throttle_p = scf_pkg::axis_pulse(scf_pkg::GAIN_THROTTLE, i_axis_throttle);
    assign yaw_force  = throttle_p < scf_pkg::THR_FORCE_LIMIT;

    always_comb begin
        n_roll     = r_roll;
        n_pitch    = r_pitch;
        n_yaw      = r_yaw;
        n_throttle = r_throttle;
        n_height   = r_height;
        n_offset   = r_offset;
        n_alt      = r_alt;
        n_flags    = r_flags;
        o_push     = 1'b0;

        o_push_frame.roll     = r_roll;
        o_push_frame.pitch    = r_pitch;
        o_push_frame.yaw      = r_yaw;
        o_push_frame.throttle = r_throttle;
        o_push_frame.height   = r_height + r_offset;
        o_push_frame.flags    = r_flags;

        if (i_accept) begin
            case (scf_pkg::t_cmd'(i_cmd))
                scf_pkg::CMD_SAMPLE: begin
                    if (i_hat == scf_pkg::HAT_UP) begin
                        n_height = r_height + 32'd1;
                    end else if (i_hat == scf_pkg::HAT_DOWN) begin
                        n_height = r_height - 32'd1;
                    end
                    n_roll     = scf_pkg::axis_pulse(scf_pkg::GAIN_ROLL, i_axis_roll);
                    n_pitch    = scf_pkg::axis_pulse(scf_pkg::GAIN_PITCH, i_axis_pitch);
                    n_throttle = throttle_p;
                    if (i_buttons[scf_pkg::BTN_YAW_DOWN] && yaw_force) begin
                        n_yaw = scf_pkg::YAW_PULSE_MIN;
                    end else if (i_buttons[scf_pkg::BTN_YAW_UP] && yaw_force) begin
                        n_yaw = scf_pkg::YAW_PULSE_MAX;
                    end else begin
                        n_yaw = scf_pkg::axis_pulse(scf_pkg::GAIN_YAW, i_axis_yaw);
                    end
                    if (i_buttons[scf_pkg::BTN_SERVO_OFF]) begin
                        n_flags[scf_pkg::FLAG_SERVO] = 1'b0;
                    end
                    if (i_buttons[scf_pkg::BTN_SERVO_ON]) begin
                        n_flags[scf_pkg::FLAG_SERVO] = 1'b1;
                    end
                    if (i_buttons[scf_pkg::BTN_ALT_OFF]) begin
                        n_flags[scf_pkg::FLAG_ALT] = 1'b0;
                        n_height = '0;
                    end
                    if (i_buttons[scf_pkg::BTN_ALT_ON]) begin
                        n_flags[scf_pkg::FLAG_ALT] = 1'b1;
                        n_offset = r_alt;
                        n_height = '0;
                    end
                end
                scf_pkg::CMD_SEND: begin
                    o_push = 1'b1;
                    n_flags[scf_pkg::FLAG_SEND] = 1'b0;
                end
                scf_pkg::CMD_TELEM: begin
                    n_alt = i_telemetry_altitude;
                end
                scf_pkg::CMD_TAKEOFF: begin
                    n_flags[scf_pkg::FLAG_ALT] = 1'b1;
                    n_offset = r_alt;
                    n_height = i_takeoff_height;
                end
                scf_pkg::CMD_LAND: begin
                    n_height = scf_pkg::LAND_HEIGHT;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll     <= '0;
            r_pitch    <= '0;
            r_yaw      <= '0;
            r_throttle <= '0;
            r_height   <= '0;
            r_offset   <= '0;
            r_alt      <= '0;
            r_flags    <= '0;
        end else begin
            r_roll     <= n_roll;
            r_pitch    <= n_pitch;
            r_yaw      <= n_yaw;
            r_throttle <= n_throttle;
            r_height   <= n_height;
            r_offset   <= n_offset;
            r_alt      <= n_alt;
            r_flags    <= n_flags;
        end
    end

endmodule

// ===== hw/rtl/scf_queue.sv =====
// two-entry queue of frame snapshots between front end and serializer
// depends on scf_pkg for the frame type
module scf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scf_pkg::t_frame i_push_frame,
    input  logic            i_pop,
    output scf_pkg::t_frame o_head,
    output logic            o_empty,
    output logic            o_full
);

    scf_pkg::t_frame r_mem [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_count, n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/scf_back.sv =====
// serializer: walks a frame snapshot byte by byte and appends the xor checksum
// depends on scf_pkg; pops frames from scf_queue
module scf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  scf_pkg::t_frame i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_last
);

    logic                          r_busy, n_busy;
    logic [scf_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [7:0]                    r_csum, n_csum;
    scf_pkg::t_frame               r_frame, n_frame;
    logic                          r_valid, n_valid;
    logic [7:0]                    r_data, n_data;
    logic                          r_last, n_last;

    logic       adv;
    logic [7:0] cur_byte;

    assign adv      = !r_valid || i_ready;
    assign cur_byte = scf_pkg::frame_byte(r_frame, r_idx, r_csum);

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_csum  = r_csum;
        n_frame = r_frame;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        o_pop   = 1'b0;

        if (adv) begin
            n_valid = r_busy;
            if (r_busy) begin
                n_data = cur_byte;
                n_last = (r_idx == scf_pkg::LAST_IDX);
                n_idx  = r_idx + 1'b1;
                if (r_idx >= scf_pkg::CSUM_FIRST && r_idx <= scf_pkg::CSUM_LAST) begin
                    n_csum = r_csum ^ cur_byte;
                end
                if (r_idx == scf_pkg::LAST_IDX) begin
                    n_busy = 1'b0;
                end
            end
        end

        // next frame loads from a non-empty queue while idle, or as soon as the current one moves its last byte out
        if ((!r_busy || (adv && r_idx == scf_pkg::LAST_IDX)) && !i_empty) begin
            o_pop   = 1'b1;
            n_busy  = 1'b1;
            n_idx   = '0;
            n_csum  = '0;
            n_frame = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_csum  <= n_csum;
        r_frame <= n_frame;
        r_data  <= n_data;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== hw/rtl/stick_command_framer.sv =====
// stick command framer top level: input stream, front end, frame queue, serializer
// depends on scf_pkg, scf_front, scf_queue and scf_back
//
// Turns joystick samples and vehicle events into 17-byte command frames. Each
// input transaction carries a command in tuser (0 stick sample, 1 send tick,
// 2 telemetry altitude, 3 takeoff, 4 landing; 5..7 are ignored) and all raw
// fields in tdata. Unless the frame queue is full, the front end takes one
// transaction per clock and updates the pulse, height, offset, altitude and flag
// registers in that same cycle; a send tick snapshots those registers, with
// height plus offset already summed, into a two-entry frame queue. The
// serializer drains the queue one byte per clock while the output side is ready:
// three header bytes, the four pulses high byte first, the 32-bit height low byte
// first, the flag byte and an xor checksum over bytes 3..15, which carries tlast.
// Frames follow each other without a gap while the output side is ready. Input
// tready drops only while both queue entries hold frames that have not begun to
// serialize, so that is set by the serializer and the output back-pressure.
module stick_command_framer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata from bit 0: axis_roll[15:0], axis_pitch[31:16], axis_yaw[47:32],
    // axis_throttle[63:48], buttons[75:64], hat[79:76],
    // telemetry_altitude[111:80], takeoff_height[143:112]
    input  logic [143:0] i_s_axis_tdata,
    // tuser from bit 0: command[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    // output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata from bit 0: frame_byte[7:0]
    output logic [7:0]   o_m_axis_tdata,
    // tlast: last_byte, set on the checksum byte
    output logic         o_m_axis_tlast
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;
    scf_pkg::t_frame push_frame;
    scf_pkg::t_frame head_frame;

    // a transaction is taken whenever the queue has room for a frame
    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    scf_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_cmd                (i_s_axis_tuser),
        .i_axis_roll          (i_s_axis_tdata[15:0]),
        .i_axis_pitch         (i_s_axis_tdata[31:16]),
        .i_axis_yaw           (i_s_axis_tdata[47:32]),
        .i_axis_throttle      (i_s_axis_tdata[63:48]),
        .i_buttons            (i_s_axis_tdata[75:64]),
        .i_hat                (i_s_axis_tdata[79:76]),
        .i_telemetry_altitude (i_s_axis_tdata[111:80]),
        .i_takeoff_height     (i_s_axis_tdata[143:112]),
        .o_push               (push),
        .o_push_frame         (push_frame)
    );

    // frame snapshots wait here so the front end keeps taking samples
    scf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_frame (push_frame),
        .i_pop        (pop),
        .o_head       (head_frame),
        .o_empty      (q_empty),
        .o_full       (q_full)
    );

    // byte serializer with a registered output stage
    scf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_frame),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== test/stick_command_framer_test.sv =====
// self-checking testbench for stick_command_framer: directed and random command streams
// predicts every frame byte from its own copy of the block state; depends on scf_pkg
`timescale 1ns / 100ps

module stick_command_framer_test;
    import scf_pkg::*;

    // run limits
    localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off to fill the frame queue
    localparam int DRAIN_CYCLES = 40;    // quiet time after the last expected byte
    localparam int RANDOM_ITEMS = 80;

    // pulse mapping
    localparam int K_ROLL     = 250;
    localparam int K_PITCH    = -250;
    localparam int K_YAW      = 250;
    localparam int K_THROTTLE = -500;
    localparam int MID_PULSE  = 1500;
    localparam int LOW_THR    = 1100;
    localparam logic [10:0] YAW_FORCED_LOW  = 11'd1000;
    localparam logic [10:0] YAW_FORCED_HIGH = 11'd2000;

    // packed so that the last field lands in the lowest tdata bits
    typedef struct packed {
        logic [31:0] takeoff_h;
        logic [31:0] telem_alt;
        logic [3:0]  hat;
        logic [11:0] btn;
        logic [15:0] throttle;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
    } t_stick_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    // dut signals; the inputs are known from time zero
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [143:0] i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;
    logic         o_m_axis_tlast;

    // predicted block state
    logic [10:0] roll_pw = '0;
    logic [10:0] pitch_pw = '0;
    logic [10:0] yaw_pw = '0;
    logic [10:0] thr_pw = '0;
    logic [31:0] height_sp = '0;
    logic [31:0] alt_offset = '0;
    logic [31:0] last_alt = '0;
    logic [2:0]  flags = '0;

    // bytes the serializer still owes us, oldest first
    t_frame_byte pending_frame_bytes[$];

    int  errors = 0;
    int  n_accepted = 0;
    int  n_frames = 0;
    int  n_bytes = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;      // sender offers back to back while set
    bit  rx_hold_req = 1'b0;  // asks the receiver for one long hold-off

    stick_command_framer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // (k * raw) / 32768 truncated toward zero, plus center, kept at 11 bits
    function automatic logic [10:0] pulse_of(input int gain, input logic signed [15:0] raw);
        int p;
        p = (gain * int'(raw)) / 32768 + MID_PULSE;
        return p[10:0];
    endfunction

    // snapshot of the state as a 17-byte frame, queued for the checker
    task automatic queue_frame();
        logic [7:0]  b [FRAME_LEN];
        logic [31:0] h;
        logic [7:0]  csum;
        int          k;
        h     = height_sp + alt_offset;
        b[0]  = HDR0;
        b[1]  = HDR1;
        b[2]  = HDR2;
        b[3]  = {5'b0, roll_pw[10:8]};
        b[4]  = roll_pw[7:0];
        b[5]  = {5'b0, pitch_pw[10:8]};
        b[6]  = pitch_pw[7:0];
        b[7]  = {5'b0, yaw_pw[10:8]};
        b[8]  = yaw_pw[7:0];
        b[9]  = {5'b0, thr_pw[10:8]};
        b[10] = thr_pw[7:0];
        // height goes out low byte first
        b[11] = h[7:0];
        b[12] = h[15:8];
        b[13] = h[23:16];
        b[14] = h[31:24];
        b[15] = {5'b0, flags};
        csum  = '0;
        for (k = 3; k < FRAME_LEN - 1; k++)
            csum ^= b[k];
        b[FRAME_LEN-1] = csum;
        for (k = 0; k < FRAME_LEN; k++)
            pending_frame_bytes.push_back('{data: b[k], last: (k == FRAME_LEN - 1)});
        flags[FLAG_SEND] = 1'b0;
        n_frames++;
    endtask

    // state update for one accepted input transaction
    task automatic track_command(input logic [2:0] cmd, input t_stick_item it);
        case (cmd)
            CMD_SAMPLE: begin
                // hat step first, only for exactly up or exactly down
                if (it.hat == HAT_UP)
                    height_sp = height_sp + 32'd1;
                else if (it.hat == HAT_DOWN)
                    height_sp = height_sp - 32'd1;
                roll_pw  = pulse_of(K_ROLL, it.roll);
                pitch_pw = pulse_of(K_PITCH, it.pitch);
                thr_pw   = pulse_of(K_THROTTLE, it.throttle);
                // yaw override only while throttle is low, low button wins
                if (it.btn[BTN_YAW_DOWN] && thr_pw < LOW_THR)
                    yaw_pw = YAW_FORCED_LOW;
                else if (it.btn[BTN_YAW_UP] && thr_pw < LOW_THR)
                    yaw_pw = YAW_FORCED_HIGH;
                else
                    yaw_pw = pulse_of(K_YAW, it.yaw);
                // servo: clear then set, so set wins
                if (it.btn[BTN_SERVO_OFF])
                    flags[FLAG_SERVO] = 1'b0;
                if (it.btn[BTN_SERVO_ON])
                    flags[FLAG_SERVO] = 1'b1;
                if (it.btn[BTN_ALT_OFF]) begin
                    flags[FLAG_ALT] = 1'b0;
                    height_sp = '0;
                end
                if (it.btn[BTN_ALT_ON]) begin
                    flags[FLAG_ALT] = 1'b1;
                    alt_offset = last_alt;
                    height_sp = '0;
                end
            end
            CMD_SEND: queue_frame();
            CMD_TELEM: last_alt = it.telem_alt;
            CMD_TAKEOFF: begin
                flags[FLAG_ALT] = 1'b1;
                alt_offset = last_alt;
                height_sp = it.takeoff_h;
            end
            CMD_LAND: height_sp = -32'sd40;
            default: ;  // unused codes leave everything alone
        endcase
    endtask

    // mostly short gaps, a few long ones, none while bursting
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one input transaction, wait for the handshake, then maybe idle
    task automatic send_item(input logic [2:0] cmd, input t_stick_item it);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= it;
        i_s_axis_tuser  <= cmd;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        track_command(cmd, it);
        n_accepted++;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stick sample with random filler in the fields it does not use
    task automatic send_sample(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw, input logic [15:0] thr,
                               input logic [11:0] btn, input logic [3:0] hat);
        t_stick_item it;
        it = '{takeoff_h: $urandom, telem_alt: $urandom, hat: hat, btn: btn,
               throttle: thr, yaw: yaw, pitch: pitch, roll: roll};
        send_item(CMD_SAMPLE, it);
    endtask

    // any other command; value goes to both 32-bit fields, the rest is noise
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] value);
        t_stick_item it;
        it = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.telem_alt = value;
        it.takeoff_h = value;
        send_item(cmd, it);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // frame straight out of reset: all registers zero
    task automatic test_reset_frame();
        send_cmd(CMD_SEND, $urandom);
    endtask

    // most negative and most positive readings on every axis
    task automatic test_axis_extremes();
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 12'h000, 4'd0);
        send_cmd(CMD_SEND, $urandom);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 12'h000, 4'd0);
        send_cmd(CMD_SEND, $urandom);
    endtask

    // yaw forced by buttons 2 and 3, right around the throttle threshold
    task automatic test_yaw_override();
        // throttle pulse 1001: low button forces yaw down
        send_sample(16'h1234, 16'h4321, 16'h2000, 16'h7FFF, 12'b1 << BTN_YAW_DOWN, 4'd2);
        send_cmd(CMD_SEND, $urandom);
        // throttle pulse 1099: high button forces yaw up
        send_sample(16'hEDCB, 16'h0001, 16'hE000, 16'd26280, 12'b1 << BTN_YAW_UP, 4'd8);
        send_cmd(CMD_SEND, $urandom);
        // throttle pulse exactly 1100: no override even with both pressed
        send_sample(16'h0001, 16'hFFFF, 16'h4000, 16'd26279,
                    (12'b1 << BTN_YAW_DOWN) | (12'b1 << BTN_YAW_UP), 4'd0);
        send_cmd(CMD_SEND, $urandom);
    endtask

    // hat steps wrapping at 32 bits, landing height, hat values that do nothing
    task automatic test_height_hat();
        send_cmd(CMD_TAKEOFF, 32'h7FFF_FFFF);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'h000, HAT_UP);
        send_cmd(CMD_SEND, $urandom);
        send_cmd(CMD_LAND, $urandom);
        send_sample(16'h0100, 16'h0200, 16'h0300, 16'h0400, 12'h002, HAT_DOWN);
        send_sample(16'h0100, 16'h0200, 16'h0300, 16'h0400, 12'h000, 4'd5);
        send_cmd(CMD_SEND, $urandom);
    endtask

    // servo and altitude-mode buttons, telemetry capture, unused commands
    task automatic test_mode_buttons();
        send_cmd(CMD_TELEM, 32'h8765_4321);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    (12'b1 << BTN_SERVO_ON) | (12'b1 << BTN_ALT_ON) | 12'h0F3, HAT_UP);
        send_cmd(CMD_SEND, $urandom);
        // both servo buttons: set wins
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    (12'b1 << BTN_SERVO_OFF) | (12'b1 << BTN_SERVO_ON), HAT_UP);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    (12'b1 << BTN_SERVO_OFF) | (12'b1 << BTN_ALT_OFF), 4'd0);
        send_cmd(CMD_SEND, $urandom);
        // both altitude buttons: mode ends up on, height zero
        send_cmd(CMD_TELEM, 32'h0000_1000);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    (12'b1 << BTN_ALT_OFF) | (12'b1 << BTN_ALT_ON), HAT_DOWN);
        send_cmd(3'd5, $urandom);
        send_cmd(3'd6, $urandom);
        send_cmd(3'd7, $urandom);
        send_cmd(CMD_SEND, $urandom);
    endtask

    // receiver holds off for a long stretch while send ticks keep coming
    task automatic test_output_stall();
        int k;
        rx_hold_req = 1'b1;
        no_gaps = 1'b1;
        for (k = 0; k < 6; k++)
            send_cmd(CMD_SEND, $urandom);
        no_gaps = 1'b0;
    endtask

    // weighted random commands with random content and bursts
    task automatic test_random_traffic();
        int          done;
        int          r;
        logic [2:0]  cmd;
        t_stick_item it;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done % 25 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            it = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
            r = $urandom_range(0, 99);
            if (r < 55) begin
                cmd = CMD_SAMPLE;
                it.roll  = rand_axis();
                it.pitch = rand_axis();
                it.yaw   = rand_axis();
                // often push throttle into the yaw override range
                it.throttle = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(26000, 32767))
                                                          : rand_axis();
                it.btn = 12'($urandom & $urandom);
                case ($urandom_range(0, 4))
                    0, 1:    it.hat = HAT_UP;
                    2:       it.hat = HAT_DOWN;
                    default: it.hat = 4'($urandom);
                endcase
            end else if (r < 75) begin
                cmd = CMD_SEND;
            end else if (r < 83) begin
                cmd = CMD_TELEM;
            end else if (r < 89) begin
                cmd = CMD_TAKEOFF;
            end else if (r < 94) begin
                cmd = CMD_LAND;
            end else begin
                cmd = 3'($urandom_range(5, 7));
            end
            send_item(cmd, it);
            if (cmd <= CMD_LAND)
                done++;
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------- checker

    task automatic check_frame_byte(input logic [7:0] data, input logic last);
        t_frame_byte want;
        if (pending_frame_bytes.size() == 0) begin
            errors++;
            $display("%0t: frame byte with nothing expected: data %02h last %0b",
                     $time, data, last);
        end else begin
            want = pending_frame_bytes.pop_front();
            if (data !== want.data) begin
                errors++;
                $display("%0t: frame byte mismatch: expected %02h actual %02h",
                         $time, want.data, data);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: tlast mismatch: expected %0b actual %0b",
                         $time, want.last, last);
            end
            n_bytes++;
        end
    endtask

    // output side: check each accepted transaction, then choose next tready
    initial begin : rx_side
        int stall_left;
        int mode_left;
        int r;
        bit calm;
        stall_left = 0;
        mode_left  = 0;
        calm       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                check_frame_byte(o_m_axis_tdata, o_m_axis_tlast);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            // alternate stretches with and without stalls
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if (calm) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_m_axis_tready <= 1'b1;
                end else if (r < 95) begin
                    i_m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    i_m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(8, 30);
                end
            end
        end
    end

    // watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("stick_command_framer_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : main_seq
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_frame();
        test_axis_extremes();
        test_yaw_override();
        test_height_hat();
        test_mode_buttons();
        test_output_stall();
        test_random_traffic();
        i_s_axis_tvalid <= 1'b0;

        // drain the serializer, then watch for stray bytes
        while (pending_frame_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transactions, %0d frames, %0d frame bytes checked",
                 n_accepted, n_frames, n_bytes);
        $display("axis extremes, yaw override edges, hat wrap, mode buttons, long output stall");
        if (errors == 0)
            $display("stick_command_framer_test: clean");
        else
            $display("stick_command_framer_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/scf_pkg.sv
hw/rtl/scf_front.sv
hw/rtl/scf_queue.sv
hw/rtl/scf_back.sv
hw/rtl/stick_command_framer.sv
test/stick_command_framer_test.sv
